// File: hdl/gesr_pkg.sv
// shared types, constants and helpers for the graph edge store
package gesr_pkg;

  localparam int NodeCount = 64;
  localparam int NodeW     = $clog2(NodeCount);

  typedef logic [NodeW-1:0]     node_t;
  typedef logic [NodeCount-1:0] row_t;

  localparam logic OpInsert = 1'b0;
  localparam logic OpQuery  = 1'b1;

  // one-hot row mask for a node
  function automatic row_t node_bit(node_t idx);
    row_t one;
    one = row_t'(1);
    return one << idx;
  endfunction

  // index of the lowest set bit, zero when none is set
  function automatic node_t lowest_idx(row_t x);
    row_t  oh;
    node_t idx;
    oh  = x & (~x + row_t'(1));
    idx = '0;
    for (int i = 0; i < NodeCount; i++) begin
      if (oh[i]) begin
        idx = idx | node_t'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: hdl/graph_edge_store_reachability.sv
// undirected graph edge store with an edge insert and a reachability query
//
// The graph lives in a 64 x 64 adjacency memory with one write port and one
// synchronous read port; a valid flop per row makes every row read as empty
// after reset, so there is no clearing pass. A request is taken only while the
// block is idle, and the result sits in an output register, so a new request
// can be taken while the previous result waits. An insert reads row a, writes
// it back with bit b set while reading row b, then writes row b with bit a set;
// a self-loop is rejected. A query walks the graph from node_a, reading one
// adjacency row per cycle, at most one for each node it reaches, and stops
// early once node_b is seen; at most 63 rows are read, since node_b itself is
// never expanded; a query with node_a equal to node_b needs no walk.
// The single memory read port sets the pace of the walk.
module graph_edge_store_reachability (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 opcode_i,
  input  gesr_pkg::node_t      node_a_i,
  input  gesr_pkg::node_t      node_b_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 path_found_o,
  output logic                 edge_added_o,
  output logic                 rejected_o
);
  import gesr_pkg::*;

  // control states
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StInsA = 3'd1;  // row a data back, write it, read row b
  localparam logic [2:0] StInsB = 3'd2;  // row b data back, write it
  localparam logic [2:0] StQry  = 3'd3;  // walk loop, one row read per cycle
  localparam logic [2:0] StFin  = 3'd4;  // result ready, waits for output slot

  logic [2:0] state_q, state_d;

  // request held for the duration of the work
  node_t a_q, b_q;

  // walk state
  row_t visited_q, visited_d;
  row_t pending_q, pending_d;
  logic inflight_q, inflight_d;

  // result waiting to move into the output register
  logic res_found_q, res_found_d;
  logic res_added_q, res_added_d;
  logic res_rej_q, res_rej_d;

  // output register
  logic out_valid_q, out_valid_d;
  logic out_found_q, out_added_q, out_rej_q;

  // adjacency memory and per-row valid flops
  row_t adj_mem [NodeCount];
  row_t row_valid_q;
  row_t rd_data_q;
  logic rd_row_valid_q;

  logic  rd_en;
  node_t rd_addr;
  logic  wr_en;
  node_t wr_addr;
  row_t  wr_data;

  logic in_req;
  logic out_free;
  row_t row;       // row read last cycle, empty if never written
  row_t fresh;     // newly reached nodes this cycle
  row_t vis_eff;
  row_t pend_eff;
  node_t pick;

  assign in_ready_o   = (state_q == StIdle);
  assign in_req       = in_valid_i && in_ready_o;
  assign out_free     = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign path_found_o = out_found_q;
  assign edge_added_o = out_added_q;
  assign rejected_o   = out_rej_q;

  assign row      = rd_row_valid_q ? rd_data_q : '0;
  // merge the row that came back, if a read was in flight
  assign fresh    = inflight_q ? (row & ~visited_q) : '0;
  assign vis_eff  = visited_q | fresh;
  assign pend_eff = pending_q | fresh;
  assign pick     = lowest_idx(pend_eff);

  always_comb begin
    state_d     = state_q;
    visited_d   = visited_q;
    pending_d   = pending_q;
    inflight_d  = 1'b0;
    res_found_d = res_found_q;
    res_added_d = res_added_q;
    res_rej_d   = res_rej_q;
    rd_en       = 1'b0;
    rd_addr     = node_a_i;
    wr_en       = 1'b0;
    wr_addr     = a_q;
    wr_data     = row | node_bit(b_q);

    case (state_q)
      StIdle: begin
        if (in_req) begin
          res_found_d = 1'b0;
          res_added_d = 1'b0;
          res_rej_d   = 1'b0;
          if (opcode_i == OpInsert) begin
            if (node_a_i == node_b_i) begin
              // self-loop is refused, graph untouched
              res_rej_d = 1'b1;
              state_d   = StFin;
            end else begin
              rd_en   = 1'b1;
              rd_addr = node_a_i;
              state_d = StInsA;
            end
          end else begin
            if (node_a_i == node_b_i) begin
              // a node always reaches itself
              res_found_d = 1'b1;
              state_d     = StFin;
            end else begin
              visited_d = node_bit(node_a_i);
              pending_d = node_bit(node_a_i);
              state_d   = StQry;
            end
          end
        end
      end
      StInsA: begin
        // rows are symmetric, so row a alone tells whether the edge is new
        res_added_d = !row[b_q];
        wr_en       = 1'b1;
        wr_addr     = a_q;
        wr_data     = row | node_bit(b_q);
        rd_en       = 1'b1;
        rd_addr     = b_q;
        state_d     = StInsB;
      end
      StInsB: begin
        wr_en   = 1'b1;
        wr_addr = b_q;
        wr_data = row | node_bit(a_q);
        state_d = StFin;
      end
      StQry: begin
        visited_d = vis_eff;
        if (vis_eff[b_q]) begin
          // target reached, no need to finish the walk
          res_found_d = 1'b1;
          state_d     = StFin;
        end else if (pend_eff == '0) begin
          // nothing left to expand and nothing in flight
          res_found_d = 1'b0;
          state_d     = StFin;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = pick;
          pending_d  = pend_eff & ~node_bit(pick);
          inflight_d = 1'b1;
        end
      end
      StFin: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // output register moves on when the result is handed over
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == StFin && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      inflight_q  <= 1'b0;
      out_valid_q <= 1'b0;
      row_valid_q <= '0;
      visited_q   <= '0;
      pending_q   <= '0;
    end else begin
      state_q     <= state_d;
      inflight_q  <= inflight_d;
      out_valid_q <= out_valid_d;
      visited_q   <= visited_d;
      pending_q   <= pending_d;
      if (wr_en) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    res_found_q <= res_found_d;
    res_added_q <= res_added_d;
    res_rej_q   <= res_rej_d;
    if (in_req) begin
      a_q <= node_a_i;
      b_q <= node_b_i;
    end
    if (state_q == StFin && out_free) begin
      out_found_q <= res_found_q;
      out_added_q <= res_added_q;
      out_rej_q   <= res_rej_q;
    end
  end

  // adjacency memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      adj_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q      <= adj_mem[rd_addr];
      rd_row_valid_q <= row_valid_q[rd_addr];
    end
  end

endmodule

// File: hdl/gesr_checker.sv
// port-level checker for the graph edge store, bound to the top level
module gesr_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic            path_found_o,
  input logic            edge_added_o,
  input logic            rejected_o
);

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(path_found_o) && $stable(edge_added_o)
      && $stable(rejected_o))
    else $error("result changed while stalled");

  // one request at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  // a result is either a query answer or an insert status, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(path_found_o && (edge_added_o || rejected_o))
      && !(edge_added_o && rejected_o))
    else $error("inconsistent result flags");

endmodule

bind graph_edge_store_reachability gesr_checker u_gesr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .path_found_o (path_found_o),
  .edge_added_o (edge_added_o),
  .rejected_o   (rejected_o)
);

// File: verif/graph_edge_store_reachability_test.sv
// self-checking testbench for the graph edge store with reachability query
module graph_edge_store_reachability_test;
  import gesr_pkg::*;

  // one result item as the block reports it
  typedef struct packed {
    logic path_found;
    logic edge_added;
    logic rejected;
  } graph_result_t;

  localparam int ClkHalf      = 6;
  localparam int ResetCycles  = 8;
  localparam int MaxIdle      = 18;
  // wait a little longer than the worst query walk
  localparam int SettleCycles = 80;
  // run-away limit, set well above the slowest correct run of all requests
  // plus the hold-off
  localparam int CycleLimit   = 600000;
  localparam int HoldOffCycles = 300;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  in_valid_i  = 1'b0;
  logic  in_ready_o;
  logic  opcode_i    = OpInsert;
  node_t node_a_i    = '0;
  node_t node_b_i    = '0;
  logic  out_valid_o;
  logic  out_ready_i = 1'b0;
  logic  path_found_o;
  logic  edge_added_o;
  logic  rejected_o;

  // own copy of the adjacency matrix, updated as requests are accepted
  row_t          graph_rows [NodeCount] = '{default: '0};
  // answers still owed by the block, oldest first
  graph_result_t pending_results [$];

  int error_count = 0;
  int cycle_count = 0;
  // shared switch for random idling on both sides
  bit idle_on     = 1'b1;
  // long receiver hold-off, picked up and counted by the result process
  int hold_cycles = 0;

  graph_edge_store_reachability i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .path_found_o(path_found_o),
    .edge_added_o(edge_added_o),
    .rejected_o  (rejected_o)
  );

  always #ClkHalf clk_i = ~clk_i;

  // run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  // breadth-first walk over our matrix: visited set grows by one frontier per round
  function automatic logic node_reachable(node_t src, node_t dst);
    row_t seen;
    row_t front;
    row_t next;
    seen  = row_t'(1) << src;
    front = seen;
    while (front != '0) begin
      next = '0;
      for (int n = 0; n < NodeCount; n++) begin
        if (front[n]) begin
          next |= graph_rows[n];
        end
      end
      front = next & ~seen;
      seen  |= front;
    end
    return seen[dst];
  endfunction

  // expected answer for one request; an insert also updates the matrix
  function automatic graph_result_t predict_graph_result(logic op, node_t a, node_t b);
    graph_result_t res;
    res = '0;
    if (op == OpInsert) begin
      if (a == b) begin
        // self-loop: refused, graph untouched
        res.rejected = 1'b1;
      end else begin
        res.edge_added = !graph_rows[a][b];
        graph_rows[a][b] = 1'b1;
        graph_rows[b][a] = 1'b1;
      end
    end else begin
      // a node always reaches itself, whatever the edges
      res.path_found = (a == b) ? 1'b1 : node_reachable(a, b);
    end
    return res;
  endfunction

  // offer one request and wait for the accepting edge; valid is only lowered
  // when a gap follows, so back-to-back requests never see two writes per step
  task automatic offer_request(input logic op, input node_t a, input node_t b);
    int gap;
    bit taken;
    gap = idle_on ? $urandom_range(0, MaxIdle) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    node_a_i   <= a;
    node_b_i   <= b;
    // ready comes from block state only, so it is steady from the falling edge on
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    pending_results.insert(pending_results.size(), predict_graph_result(op, a, b));
  endtask

  // drop valid and let every owed result come back, then let the block settle
  task automatic drain_results;
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // result side: random stall per result, optional long hold-off, then check
  initial begin
    int            stall;
    bit            seen_valid;
    graph_result_t got;
    graph_result_t want;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, MaxIdle) : 0;
      if (hold_cycles > 0) begin
        stall       = hold_cycles;
        hold_cycles = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      // outputs are registered, so sample them ahead of the accepting edge
      do begin
        @(negedge clk_i);
        seen_valid = out_valid_o;
        got = '{path_found: path_found_o, edge_added: edge_added_o, rejected: rejected_o};
        @(posedge clk_i);
      end while (!seen_valid);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual found=%0b added=%0b rejected=%0b",
                 $time, got.path_found, got.edge_added, got.rejected);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          $display({"%0t: result mismatch, expected found=%0b added=%0b rejected=%0b,",
                    " actual found=%0b added=%0b rejected=%0b"},
                   $time, want.path_found, want.edge_added, want.rejected,
                   got.path_found, got.edge_added, got.rejected);
          error_count++;
        end
      end
    end
  end

  function automatic node_t random_node();
    return node_t'($urandom_range(0, NodeCount - 1));
  endfunction

  // queries on the empty graph, extremes of both node ids
  task automatic test_empty_graph;
    offer_request(OpQuery, 6'd0, 6'd0);
    offer_request(OpQuery, 6'd63, 6'd63);
    offer_request(OpQuery, 6'd0, 6'd63);
    offer_request(OpQuery, 6'd21, 6'd42);
  endtask

  // new edge, repeated edge both ways round, self-loops at both extremes
  task automatic test_edge_insert;
    offer_request(OpInsert, 6'd0, 6'd63);
    offer_request(OpInsert, 6'd0, 6'd63);
    offer_request(OpInsert, 6'd63, 6'd0);
    offer_request(OpInsert, 6'd7, 6'd7);
    offer_request(OpInsert, 6'd63, 6'd63);
    offer_request(OpInsert, 6'd0, 6'd0);
    offer_request(OpQuery, 6'd0, 6'd63);
    offer_request(OpQuery, 6'd63, 6'd0);
  endtask

  // multi-hop path, reverse direction, unreachable node and self queries
  task automatic test_path_chain;
    offer_request(OpInsert, 6'd1, 6'd2);
    offer_request(OpInsert, 6'd2, 6'd3);
    offer_request(OpInsert, 6'd3, 6'd62);
    offer_request(OpQuery, 6'd1, 6'd62);
    offer_request(OpQuery, 6'd62, 6'd1);
    offer_request(OpQuery, 6'd1, 6'd40);
    offer_request(OpQuery, 6'd40, 6'd1);
    offer_request(OpQuery, 6'd20, 6'd20);
    offer_request(OpQuery, 6'd40, 6'd40);
  endtask

  // edges only inside eight clusters (same low three bits), so queries
  // split between reachable and unreachable for a long time
  task automatic test_clustered_random(input int count);
    int    pick;
    node_t a;
    node_t b;
    for (int i = 0; i < count; i++) begin
      // alternate stretches with and without idling
      if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      a    = random_node();
      b    = random_node();
      if (pick < 5) begin
        // noise: self-loop insert
        offer_request(OpInsert, a, a);
      end else if (pick < 40) begin
        b[2:0] = a[2:0];
        offer_request(OpInsert, a, b);
      end else begin
        if ($urandom_range(0, 9) == 0) b = a;
        offer_request(OpQuery, a, b);
      end
    end
  endtask

  // receiver stops for a long stretch while requests keep coming, so the
  // output register fills and the block holds off its input
  task automatic test_backpressure(input int count);
    idle_on     = 1'b0;
    hold_cycles = HoldOffCycles;
    for (int i = 0; i < count; i++) begin
      offer_request(($urandom_range(0, 1) != 0) ? OpQuery : OpInsert,
                    random_node(), random_node());
    end
    idle_on = 1'b1;
  endtask

  // unrestricted inserts join the clusters; queries then walk long paths
  task automatic test_mixed_random(input int count);
    int    pick;
    node_t a;
    node_t b;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      a    = random_node();
      b    = random_node();
      if (pick < 5) begin
        offer_request(OpInsert, b, b);
      end else if (pick < 25) begin
        offer_request(OpInsert, a, b);
      end else begin
        if ($urandom_range(0, 19) == 0) b = a;
        offer_request(OpQuery, a, b);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    // reset once, then released on a clock edge
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_graph();
    test_edge_insert();
    test_path_chain();
    drain_results();

    test_clustered_random(300);
    test_backpressure(40);
    test_mixed_random(610);
    drain_results();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
